>>> rtl/bts_pkg.sv
// ----------------------------------------------------------------------------
// bts_pkg
// shared types and constants of the bilinear texture sampler
// ----------------------------------------------------------------------------
package bts_pkg;

   localparam int MAX_DIM   = 256;
   localparam int IDX_W     = $clog2(MAX_DIM);
   localparam int FRAC_BITS = 8;
   localparam int CBITS     = 24;
   localparam int BANK_AW   = 2 * (IDX_W - 1);
   localparam int BANK_DEPTH = (MAX_DIM / 2) * (MAX_DIM / 2);

   localparam logic [1:0] MODE_NONE  = 2'd0;
   localparam logic [1:0] MODE_TILE  = 2'd1;
   localparam logic [1:0] MODE_CLAMP = 2'd2;

   localparam logic CMD_LOAD   = 1'b0;
   localparam logic CMD_SAMPLE = 1'b1;

   localparam logic [2:0] REG_U_MODE        = 3'd0;
   localparam logic [2:0] REG_V_MODE        = 3'd1;
   localparam logic [2:0] REG_TEX_WIDTH     = 3'd2;
   localparam logic [2:0] REG_TEX_HEIGHT    = 3'd3;
   localparam logic [2:0] REG_U_SCALE       = 3'd4;
   localparam logic [2:0] REG_V_SCALE       = 3'd5;
   localparam logic [2:0] REG_OUTSIDE_COLOR = 3'd6;
   localparam logic [2:0] REG_HAS_ALPHA     = 3'd7;

   typedef struct packed {
      logic [1:0]  u_mode;
      logic [1:0]  v_mode;
      logic [7:0]  u_dim_m3;
      logic [7:0]  v_dim_m3;
      logic [15:0] u_scale;
      logic [15:0] v_scale;
      logic [23:0] outside_color;
      logic        has_alpha;
   } cfg_type;

   // one classified item between front and back
   typedef struct packed {
      logic                 is_load;
      logic                 outside;
      logic [IDX_W-1:0]     col;
      logic [IDX_W-1:0]     row;
      logic [FRAC_BITS-1:0] frac_u;
      logic [FRAC_BITS-1:0] frac_v;
      logic [31:0]          rgba;
   } item_type;

   typedef struct packed {
      logic       outside;
      logic       opaque;
      logic [7:0] alpha_out;
      logic [7:0] blue;
      logic [7:0] green;
      logic [7:0] red;
   } rsp_type;

endpackage

>>> rtl/bts_ram.sv
// ----------------------------------------------------------------------------
// bts_ram
// simple dual-port ram, one write and one registered read per cycle
// ----------------------------------------------------------------------------
module bts_ram #(
   parameter int WIDTH = 32,
   parameter int DEPTH = 16384
) (
   input  logic                     clock,
   input  logic                     we,
   input  logic [$clog2(DEPTH)-1:0] waddr,
   input  logic [WIDTH-1:0]         wdata,
   input  logic [$clog2(DEPTH)-1:0] raddr,
   output logic [WIDTH-1:0]         rdata_ff
);
   logic [WIDTH-1:0] mem [DEPTH];

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end
endmodule

>>> rtl/bts_fifo.sv
// ----------------------------------------------------------------------------
// bts_fifo
// small first-word-fall-through queue with free-slot count
// ----------------------------------------------------------------------------
module bts_fifo #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 4
) (
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       push,
   input  logic [WIDTH-1:0]           push_data,
   input  logic                       pop,
   output logic [WIDTH-1:0]           pop_data,
   output logic                       empty,
   output logic [$clog2(DEPTH+1)-1:0] free
);
   localparam int AW = $clog2(DEPTH);
   localparam int CW = $clog2(DEPTH + 1);

   logic [WIDTH-1:0] slot_ff [DEPTH];
   logic [AW-1:0] wr_ff, wr_in, rd_ff, rd_in;
   logic [CW-1:0] count_ff, count_in;

   always_comb begin
      wr_in = wr_ff;
      rd_in = rd_ff;
      if (push) begin
         wr_in = (wr_ff == AW'(DEPTH - 1)) ? '0 : wr_ff + AW'(1);
      end
      if (pop) begin
         rd_in = (rd_ff == AW'(DEPTH - 1)) ? '0 : rd_ff + AW'(1);
      end
      count_in = count_ff + CW'(push) - CW'(pop);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ff    <= '0;
         rd_ff    <= '0;
         count_ff <= '0;
      end else begin
         wr_ff    <= wr_in;
         rd_ff    <= rd_in;
         count_ff <= count_in;
      end
      if (push) begin
         slot_ff[wr_ff] <= push_data;
      end
   end

   assign pop_data = slot_ff[rd_ff];
   assign empty    = (count_ff == '0);
   assign free     = CW'(DEPTH) - count_ff;
endmodule

>>> rtl/bts_front.sv
// ----------------------------------------------------------------------------
// bts_front
// accepts items, scales and addresses coordinates, splits index and fraction
// ----------------------------------------------------------------------------
module bts_front #(
   parameter int QDEPTH = 8
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bts_pkg::cfg_type            cfg,
   input  logic                        in_valid,
   output logic                        in_ready,
   input  logic                        in_cmd,
   input  logic [7:0]                  in_x,
   input  logic [7:0]                  in_y,
   input  logic [31:0]                 in_rgba,
   input  logic [23:0]                 in_u,
   input  logic [23:0]                 in_v,
   input  logic [$clog2(QDEPTH+1)-1:0] q_free,
   output logic                        q_push,
   output bts_pkg::item_type           q_data
);
   import bts_pkg::*;

   localparam int CW = $clog2(QDEPTH + 1);
   localparam logic signed [40:0] ONE_S = 41'sd1 <<< CBITS;

   function automatic logic [25:0] addr_axis(input logic signed [40:0] s,
                                            input logic [1:0] mode);
      logic neg, over, ok;
      logic [24:0] t;
      neg  = s[40];
      over = s > ONE_S;
      ok   = 1'b1;
      case (mode)
         MODE_NONE: begin
            ok = !neg && !over;
            t  = s[24:0];
         end
         MODE_TILE: t = {1'b0, s[CBITS-1:0]};
         default: begin
            if (neg) t = '0;
            else if (over) t = ONE_S[24:0];
            else t = s[24:0];
         end
      endcase
      return {ok, t};
   endfunction

   logic accept;
   logic s1_valid_ff, s1_valid_in, s1_cmd_ff;
   logic [7:0] s1_x_ff, s1_y_ff;
   logic [31:0] s1_rgba_ff;
   logic signed [40:0] s1_su_ff, s1_su_in, s1_sv_ff, s1_sv_in;
   logic s2_valid_ff;
   item_type s2_item_ff, s2_item_in;
   logic [25:0] au, av;
   logic [32:0] pu, pv;

   assign in_ready = q_free > (CW'(s1_valid_ff) + CW'(s2_valid_ff));
   assign accept   = in_valid && in_ready;
   assign s1_valid_in = accept;
   assign s1_su_in = $signed(in_u) * $signed({1'b0, cfg.u_scale});
   assign s1_sv_in = $signed(in_v) * $signed({1'b0, cfg.v_scale});

   always_comb begin
      au = addr_axis(s1_su_ff, cfg.u_mode);
      av = addr_axis(s1_sv_ff, cfg.v_mode);
      pu = 33'(au[24:0]) * 33'(cfg.u_dim_m3);
      pv = 33'(av[24:0]) * 33'(cfg.v_dim_m3);
      s2_item_in.is_load = (s1_cmd_ff == CMD_LOAD);
      s2_item_in.rgba    = s1_rgba_ff;
      if (s1_cmd_ff == CMD_LOAD) begin
         s2_item_in.outside = 1'b0;
         s2_item_in.col     = s1_x_ff;
         s2_item_in.row     = s1_y_ff;
         s2_item_in.frac_u  = '0;
         s2_item_in.frac_v  = '0;
      end else begin
         s2_item_in.outside = !au[25] || !av[25];
         s2_item_in.col     = pu[CBITS+IDX_W-1:CBITS];
         s2_item_in.row     = pv[CBITS+IDX_W-1:CBITS];
         s2_item_in.frac_u  = pu[CBITS-1 -: FRAC_BITS];
         s2_item_in.frac_v  = pv[CBITS-1 -: FRAC_BITS];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff <= 1'b0;
         s2_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff <= s1_valid_in;
         s2_valid_ff <= s1_valid_ff;
      end
      s1_cmd_ff  <= in_cmd;
      s1_x_ff    <= in_x;
      s1_y_ff    <= in_y;
      s1_rgba_ff <= in_rgba;
      s1_su_ff   <= s1_su_in;
      s1_sv_ff   <= s1_sv_in;
      s2_item_ff <= s2_item_in;
   end

   assign q_push = s2_valid_ff;
   assign q_data = s2_item_ff;
endmodule

>>> rtl/bts_back.sv
// ----------------------------------------------------------------------------
// bts_back
// writes texels, fetches four neighbours from banked store and blends them
// ----------------------------------------------------------------------------
module bts_back #(
   parameter int ODEPTH = 4
) (
   input  logic                        clock,
   input  logic                        reset,
   input  bts_pkg::cfg_type            cfg,
   input  logic                        q_empty,
   input  bts_pkg::item_type           q_data,
   output logic                        q_pop,
   input  logic [$clog2(ODEPTH+1)-1:0] o_free,
   output logic                        o_push,
   output bts_pkg::rsp_type            o_data
);
   import bts_pkg::*;

   localparam int CW = $clog2(ODEPTH + 1);
   localparam int HW = IDX_W - 1;

   function automatic logic [7:0] blend(input logic [7:0] c00, c10, c01, c11,
                                        input logic [16:0] w00, w10, w01, w11);
      logic [24:0] acc;
      acc = 25'(c00) * 25'(w00) + 25'(c10) * 25'(w10)
          + 25'(c01) * 25'(w01) + 25'(c11) * 25'(w11);
      return acc[2*FRAC_BITS +: 8];
   endfunction

   logic [HW-1:0] col_even, col_odd, row_even, row_odd;
   logic [IDX_W:0] col_p1, row_p1;
   logic [3:0] bank_we;
   logic [BANK_AW-1:0] bank_raddr [4];
   logic [31:0] bank_rdata [4];
   logic [FRAC_BITS:0] fu_inv, fv_inv;
   logic r1_valid_ff, r1_valid_in, r1_outside_ff, r1_cp_ff, r1_rp_ff;
   logic [16:0] w00_ff, w10_ff, w01_ff, w11_ff;
   logic [16:0] w00_in, w10_in, w01_in, w11_in;
   logic [31:0] t00, t10, t01, t11;
   logic [7:0] alpha_b;

   assign q_pop = !q_empty && (o_free > CW'(r1_valid_ff));
   assign r1_valid_in = q_pop && !q_data.is_load;

   // even bank holds the even one of index and index + 1
   always_comb begin
      col_p1   = {1'b0, q_data.col} + (IDX_W + 1)'(1);
      row_p1   = {1'b0, q_data.row} + (IDX_W + 1)'(1);
      col_even = HW'(col_p1 >> 1);
      col_odd  = q_data.col[IDX_W-1:1];
      row_even = HW'(row_p1 >> 1);
      row_odd  = q_data.row[IDX_W-1:1];
      for (int b = 0; b < 4; b++) begin
         bank_raddr[b] = {(b[1] ? row_odd : row_even), (b[0] ? col_odd : col_even)};
         bank_we[b]    = q_pop && q_data.is_load &&
                         (q_data.row[0] == b[1]) && (q_data.col[0] == b[0]);
      end
      fu_inv = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(q_data.frac_u);
      fv_inv = (FRAC_BITS + 1)'(1 << FRAC_BITS) - (FRAC_BITS + 1)'(q_data.frac_v);
      w00_in = 17'(fu_inv) * 17'(fv_inv);
      w10_in = 17'(q_data.frac_u) * 17'(fv_inv);
      w01_in = 17'(fu_inv) * 17'(q_data.frac_v);
      w11_in = 17'(q_data.frac_u) * 17'(q_data.frac_v);
   end

   for (genvar g = 0; g < 4; g++) begin : g_bank
      bts_ram #(.WIDTH(32), .DEPTH(BANK_DEPTH)) u_ram (
         .clock    (clock),
         .we       (bank_we[g]),
         .waddr    ({q_data.row[IDX_W-1:1], q_data.col[IDX_W-1:1]}),
         .wdata    (q_data.rgba),
         .raddr    (bank_raddr[g]),
         .rdata_ff (bank_rdata[g])
      );
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         r1_valid_ff <= 1'b0;
      end else begin
         r1_valid_ff <= r1_valid_in;
      end
      r1_outside_ff <= q_data.outside;
      r1_cp_ff      <= q_data.col[0];
      r1_rp_ff      <= q_data.row[0];
      w00_ff        <= w00_in;
      w10_ff        <= w10_in;
      w01_ff        <= w01_in;
      w11_ff        <= w11_in;
   end

   always_comb begin
      t00 = bank_rdata[{r1_rp_ff, r1_cp_ff}];
      t10 = bank_rdata[{r1_rp_ff, ~r1_cp_ff}];
      t01 = bank_rdata[{~r1_rp_ff, r1_cp_ff}];
      t11 = bank_rdata[{~r1_rp_ff, ~r1_cp_ff}];
      alpha_b = blend(t00[7:0], t10[7:0], t01[7:0], t11[7:0],
                      w00_ff, w10_ff, w01_ff, w11_ff);
      if (r1_outside_ff) begin
         o_data.red       = cfg.outside_color[23:16];
         o_data.green     = cfg.outside_color[15:8];
         o_data.blue      = cfg.outside_color[7:0];
         o_data.alpha_out = 8'hFF;
         o_data.opaque    = 1'b1;
         o_data.outside   = 1'b1;
      end else begin
         o_data.red   = blend(t00[31:24], t10[31:24], t01[31:24], t11[31:24],
                              w00_ff, w10_ff, w01_ff, w11_ff);
         o_data.green = blend(t00[23:16], t10[23:16], t01[23:16], t11[23:16],
                              w00_ff, w10_ff, w01_ff, w11_ff);
         o_data.blue  = blend(t00[15:8], t10[15:8], t01[15:8], t11[15:8],
                              w00_ff, w10_ff, w01_ff, w11_ff);
         o_data.alpha_out = cfg.has_alpha ? alpha_b : 8'hFF;
         o_data.opaque    = !cfg.has_alpha || (alpha_b == 8'hFF);
         o_data.outside   = 1'b0;
      end
   end

   assign o_push = r1_valid_ff;
endmodule

>>> rtl/bilinear_texture_sampler.sv
// ----------------------------------------------------------------------------
// bilinear_texture_sampler
// bilinear texture filter with per-axis reject, tile or clamp addressing
// ----------------------------------------------------------------------------
// One item is taken per clock cycle, loads and samples alike, as long as the
// result side keeps up. A sample passes through two front stages, the
// classified-item queue, and the texel store read with the blend into the
// result queue. The rate is set by the texel store, split into four banks by
// column and row parity so that the four neighbours of a sample are read in
// the same cycle, one read port per bank. Loads write one bank and give no
// result. A 8-entry queue separates the front (scale, address, split) from
// the back (store access, blend), and a 4-entry result queue lets req_tready
// stay high while a finished result waits on rsp_tready. The texel store has
// no reset; sampling a texel never loaded is undefined. Configuration is to be
// written only while the block is idle; the block itself does not enforce it.
module bilinear_texture_sampler (
   input  logic        clock,
   input  logic        reset,
   // request stream
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [95:0] req_tdata,  // texel_x, texel_y, texel_rgba, u_coord, v_coord
   input  logic        req_tuser,  // cmd
   // result stream
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [39:0] rsp_tdata,  // red, green, blue, alpha_out, opaque, zero pad
   output logic        rsp_tuser,  // outside
   // register writes
   input  logic        csr_valid,
   output logic        csr_ready,
   input  logic [2:0]  csr_index,
   input  logic [23:0] csr_data
);
   import bts_pkg::*;

   localparam int QDEPTH = 8;
   localparam int ODEPTH = 4;

   logic [1:0]  u_mode_ff, v_mode_ff;
   logic [8:0]  tex_width_ff, tex_height_ff;
   logic [15:0] u_scale_ff, v_scale_ff;
   logic [23:0] outside_color_ff;
   logic        has_alpha_ff;
   logic [8:0]  width_c, height_c;
   cfg_type     cfg;

   logic q_push, q_pop, q_empty;
   item_type q_push_data, q_pop_data;
   logic [$clog2(QDEPTH+1)-1:0] q_free;
   logic o_push, o_pop, o_empty;
   rsp_type o_push_data, o_pop_data;
   logic [$clog2(ODEPTH+1)-1:0] o_free;

   // register file, always ready
   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         u_mode_ff        <= MODE_CLAMP;
         v_mode_ff        <= MODE_CLAMP;
         tex_width_ff     <= 9'd256;
         tex_height_ff    <= 9'd256;
         u_scale_ff       <= 16'd256;
         v_scale_ff       <= 16'd256;
         outside_color_ff <= '0;
         has_alpha_ff     <= 1'b0;
      end else if (csr_valid && csr_ready) begin
         unique case (csr_index)
            REG_U_MODE:        u_mode_ff        <= csr_data[1:0];
            REG_V_MODE:        v_mode_ff        <= csr_data[1:0];
            REG_TEX_WIDTH:     tex_width_ff     <= csr_data[8:0];
            REG_TEX_HEIGHT:    tex_height_ff    <= csr_data[8:0];
            REG_U_SCALE:       u_scale_ff       <= csr_data[15:0];
            REG_V_SCALE:       v_scale_ff       <= csr_data[15:0];
            REG_OUTSIDE_COLOR: outside_color_ff <= csr_data;
            REG_HAS_ALPHA:     has_alpha_ff     <= csr_data[0];
            default: ;
         endcase
      end
   end

   // dimensions limited to [4, MAX_DIM], then the slop of three removed
   always_comb begin
      width_c  = (tex_width_ff < 9'd4) ? 9'd4 :
                 (tex_width_ff > 9'(MAX_DIM)) ? 9'(MAX_DIM) : tex_width_ff;
      height_c = (tex_height_ff < 9'd4) ? 9'd4 :
                 (tex_height_ff > 9'(MAX_DIM)) ? 9'(MAX_DIM) : tex_height_ff;
      cfg.u_mode        = u_mode_ff;
      cfg.v_mode        = v_mode_ff;
      cfg.u_dim_m3      = 8'(width_c - 9'd3);
      cfg.v_dim_m3      = 8'(height_c - 9'd3);
      cfg.u_scale       = u_scale_ff;
      cfg.v_scale       = v_scale_ff;
      cfg.outside_color = outside_color_ff;
      cfg.has_alpha     = has_alpha_ff;
   end

   bts_front #(.QDEPTH(QDEPTH)) u_front (
      .clock    (clock),
      .reset    (reset),
      .cfg      (cfg),
      .in_valid (req_tvalid),
      .in_ready (req_tready),
      .in_cmd   (req_tuser),
      .in_x     (req_tdata[7:0]),
      .in_y     (req_tdata[15:8]),
      .in_rgba  (req_tdata[47:16]),
      .in_u     (req_tdata[71:48]),
      .in_v     (req_tdata[95:72]),
      .q_free   (q_free),
      .q_push   (q_push),
      .q_data   (q_push_data)
   );

   // classified items between front and back
   bts_fifo #(.WIDTH($bits(item_type)), .DEPTH(QDEPTH)) u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .pop       (q_pop),
      .pop_data  (q_pop_data),
      .empty     (q_empty),
      .free      (q_free)
   );

   bts_back #(.ODEPTH(ODEPTH)) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_empty (q_empty),
      .q_data  (q_pop_data),
      .q_pop   (q_pop),
      .o_free  (o_free),
      .o_push  (o_push),
      .o_data  (o_push_data)
   );

   // finished results waiting for the result transaction
   bts_fifo #(.WIDTH($bits(rsp_type)), .DEPTH(ODEPTH)) u_out (
      .clock     (clock),
      .reset     (reset),
      .push      (o_push),
      .push_data (o_push_data),
      .pop       (o_pop),
      .pop_data  (o_pop_data),
      .empty     (o_empty),
      .free      (o_free)
   );

   assign rsp_tvalid = !o_empty;
   assign o_pop      = rsp_tvalid && rsp_tready;
   assign rsp_tdata  = {7'd0, o_pop_data.opaque, o_pop_data.alpha_out,
                        o_pop_data.blue, o_pop_data.green, o_pop_data.red};
   assign rsp_tuser  = o_pop_data.outside;

   // queue credit never overruns
   a_queue_room : assert property (@(posedge clock) disable iff (reset)
      q_push |-> q_free != '0)
      else $error("item queue overflow");

   a_out_room : assert property (@(posedge clock) disable iff (reset)
      o_push |-> o_free != '0)
      else $error("result queue overflow");

   a_pop_nonempty : assert property (@(posedge clock) disable iff (reset)
      q_pop |-> !q_empty)
      else $error("back popped an empty queue");

   a_result_needs_item : assert property (@(posedge clock) disable iff (reset)
      o_push |-> $past(q_pop))
      else $error("result without a popped sample");
endmodule

>>> test/testbench.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// testbench
// self-checking bench for the bilinear texture sampler: texel loads, samples
// under every addressing mode, register sweeps and random stalls on both ends
// ----------------------------------------------------------------------------
module testbench;
   import bts_pkg::*;

   localparam int LIMIT_CYCLES = 400000;
   localparam int DRAIN_CYCLES = 12;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [95:0] req_tdata = '0;   // texel_x, texel_y, texel_rgba, u_coord, v_coord
   logic        req_tuser = 1'b0; // cmd
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [39:0] rsp_tdata;        // red, green, blue, alpha_out, opaque, zero pad
   logic        rsp_tuser;        // outside
   logic        csr_valid = 1'b0;
   logic        csr_ready;
   logic [2:0]  csr_index = '0;
   logic [23:0] csr_data = '0;

   bilinear_texture_sampler uut (.*);

   always #4 clock = ~clock;

   // shadow copy of the block's registers
   logic [1:0]  sh_u_mode = MODE_CLAMP, sh_v_mode = MODE_CLAMP;
   logic [8:0]  sh_width = 9'd256, sh_height = 9'd256;
   logic [15:0] sh_u_scale = 16'd256, sh_v_scale = 16'd256;
   logic [23:0] sh_outside = '0;
   logic        sh_alpha = 1'b0;

   // texel store mirror and which entries were loaded
   logic [31:0] texels [65536];
   bit          loaded [65536];

   rsp_type     pending_samples [$];
   bit          idle_on = 1'b1;
   bit          failed = 1'b0;
   int unsigned cycles = 0;
   int          items_sent = 0;

   // ---------------------------------------------------------------- predictor
   // one axis: returns 1 on reject, else the addressed value in [0, 1.0]
   function automatic bit address_axis(input longint s, input logic [1:0] mode,
                                       output longint t);
      longint one_q;
      one_q = longint'(1) << CBITS;
      t = 0;
      if (mode == MODE_NONE) begin
         if (s < 0 || s > one_q) return 1'b1;
         t = s;
      end else if (mode == MODE_TILE) begin
         t = s & (one_q - 1);
      end else begin
         t = (s < 0) ? 0 : ((s > one_q) ? one_q : s);
      end
      return 1'b0;
   endfunction

   function automatic void split_axis(input longint t, input logic [8:0] dim,
                                      output int idx, output int frac);
      longint d, p;
      d = (dim < 4) ? 4 : ((dim > MAX_DIM) ? MAX_DIM : dim);
      p = t * (d - 3);
      idx = int'(p >>> CBITS);
      frac = int'((p >>> (CBITS - FRAC_BITS)) & 8'hFF);
   endfunction

   // maps a sample to its top-left texel and fractions; 1 when rejected
   function automatic bit locate_sample(input logic [23:0] u, input logic [23:0] v,
                                        output int iu, output int iv,
                                        output int fu, output int fv);
      longint su, sv, tu, tv;
      su = $signed(u);
      sv = $signed(v);
      su = su * longint'(sh_u_scale);
      sv = sv * longint'(sh_v_scale);
      iu = 0; iv = 0; fu = 0; fv = 0;
      if (address_axis(su, sh_u_mode, tu)) return 1'b1;
      if (address_axis(sv, sh_v_mode, tv)) return 1'b1;
      split_axis(tu, sh_width, iu, fu);
      split_axis(tv, sh_height, iv, fv);
      return 1'b0;
   endfunction

   function automatic logic [7:0] blend_channel(input int sh, input int iu,
                                                input int iv, input int fu,
                                                input int fv);
      longint c00, c10, c01, c11, acc;
      c00 = (texels[iv * MAX_DIM + iu] >> sh) & 8'hFF;
      c10 = (texels[iv * MAX_DIM + iu + 1] >> sh) & 8'hFF;
      c01 = (texels[(iv + 1) * MAX_DIM + iu] >> sh) & 8'hFF;
      c11 = (texels[(iv + 1) * MAX_DIM + iu + 1] >> sh) & 8'hFF;
      acc = c00 * (256 - fu) * (256 - fv) + c10 * fu * (256 - fv)
          + c01 * (256 - fu) * fv + c11 * fu * fv;
      return acc[23:16];
   endfunction

   function automatic rsp_type predict_sample(input logic [23:0] u,
                                              input logic [23:0] v);
      rsp_type r;
      int iu, iv, fu, fv;
      if (locate_sample(u, v, iu, iv, fu, fv)) begin
         r.red = sh_outside[23:16];
         r.green = sh_outside[15:8];
         r.blue = sh_outside[7:0];
         r.alpha_out = 8'hFF;
         r.outside = 1'b1;
         r.opaque = 1'b1;
         return r;
      end
      r.red = blend_channel(24, iu, iv, fu, fv);
      r.green = blend_channel(16, iu, iv, fu, fv);
      r.blue = blend_channel(8, iu, iv, fu, fv);
      r.alpha_out = sh_alpha ? blend_channel(0, iu, iv, fu, fv) : 8'hFF;
      r.opaque = (r.alpha_out == 8'hFF);
      r.outside = 1'b0;
      return r;
   endfunction

   // ---------------------------------------------------------------- drivers
   // one request transaction, with an occasional idle cycle before it
   task automatic send_item(input logic cmd, input logic [7:0] x, input logic [7:0] y,
                            input logic [31:0] rgba, input logic [23:0] u,
                            input logic [23:0] v);
      if (idle_on && $urandom_range(99) < 16) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tuser <= cmd;
      req_tdata <= {v, u, rgba, y, x};
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      items_sent++;
      if (cmd == CMD_LOAD) begin
         texels[{y, x}] = rgba;
         loaded[{y, x}] = 1'b1;
      end else begin
         pending_samples.push_back(predict_sample(u, v));
      end
   endtask

   task automatic load_texel(input int x, input int y, input logic [31:0] rgba);
      send_item(CMD_LOAD, x[7:0], y[7:0], rgba, 24'($urandom), 24'($urandom));
   endtask

   // loads any of the four neighbours that were never written, then samples
   task automatic sample_at(input logic [23:0] u, input logic [23:0] v);
      int iu, iv, fu, fv;
      if (!locate_sample(u, v, iu, iv, fu, fv)) begin
         for (int dy = 0; dy < 2; dy++)
            for (int dx = 0; dx < 2; dx++)
               if (!loaded[(iv + dy) * MAX_DIM + iu + dx])
                  load_texel(iu + dx, iv + dy, $urandom);
      end
      send_item(CMD_SAMPLE, 8'($urandom), 8'($urandom), $urandom, u, v);
   endtask

   // sender holds off until every sample result is back and the pipe is empty
   task automatic drain;
      req_tvalid <= 1'b0;
      while (pending_samples.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic csr_write(input logic [2:0] idx, input logic [23:0] value);
      csr_valid <= 1'b1;
      csr_index <= idx;
      csr_data <= value;
      @(posedge clock);
      while (!csr_ready) @(posedge clock);
   endtask

   task automatic configure(input logic [1:0] um, input logic [1:0] vm,
                            input logic [8:0] w, input logic [8:0] h,
                            input logic [15:0] us, input logic [15:0] vs,
                            input logic [23:0] oc, input logic ha);
      drain();
      csr_write(REG_U_MODE, 24'(um));
      csr_write(REG_V_MODE, 24'(vm));
      csr_write(REG_TEX_WIDTH, 24'(w));
      csr_write(REG_TEX_HEIGHT, 24'(h));
      csr_write(REG_U_SCALE, 24'(us));
      csr_write(REG_V_SCALE, 24'(vs));
      csr_write(REG_OUTSIDE_COLOR, oc);
      csr_write(REG_HAS_ALPHA, 24'(ha));
      csr_valid <= 1'b0;
      sh_u_mode = um; sh_v_mode = vm; sh_width = w; sh_height = h;
      sh_u_scale = us; sh_v_scale = vs; sh_outside = oc; sh_alpha = ha;
   endtask

   // ---------------------------------------------------------------- tests
   task automatic test_directed;
      // default registers straight after reset: clamp, full size, unit scale
      sample_at(24'h000000, 24'h000000);
      sample_at(24'h010000, 24'h010000);            // exactly 1.0 on both axes
      sample_at(24'h7FFFFF, 24'h800000);            // coordinate extremes, clamped
      sample_at(24'h008000, 24'h004000);
      configure(MODE_NONE, MODE_NONE, 9'd16, 9'd16, 16'd256, 16'd256,
                24'hA5C3F0, 1'b1);
      sample_at(24'hFFFFFF, 24'h008000);            // u rejected below zero
      sample_at(24'h008000, 24'h010001);            // v rejected just above one
      sample_at(24'h020000, 24'hFF0000);            // both bad, u checked first
      sample_at(24'h010000, 24'h000000);            // one itself is accepted
      load_texel(3, 3, 32'h102030FF);
      load_texel(4, 3, 32'h405060FF);
      load_texel(3, 4, 32'h708090FF);
      load_texel(4, 4, 32'hA0B0C0FF);
      sample_at(24'h004000, 24'h004000);            // fully opaque neighbours
      load_texel(4, 4, 32'hFFFFFF00);
      sample_at(24'h004000, 24'h004000);            // translucent blend
      configure(MODE_TILE, 2'd3, 9'd0, 9'd511, 16'd0, 16'hFFFF, 24'hFFFFFF, 1'b0);
      sample_at(24'h020000, 24'h000001);            // whole number tiles to zero, mode 3
      sample_at(24'h7FFFFF, 24'h800000);
      configure(MODE_TILE, MODE_TILE, 9'd256, 9'd4, 16'd256, 16'd256, 24'd0, 1'b0);
      sample_at(24'h030000, 24'hFE8000);            // tile of whole and negative
      sample_at(24'hFFC000, 24'h018000);
   endtask

   function automatic logic [23:0] random_coord;
      if ($urandom_range(99) < 15) return 24'($urandom);
      return 24'($urandom_range(0, 24'h20000)) - 24'h8000;
   endfunction

   function automatic logic [15:0] random_scale;
      case ($urandom_range(5))
         0: return 16'd0;
         1: return 16'hFFFF;
         2, 3: return 16'd256;
         default: return 16'($urandom_range(64, 1024));
      endcase
   endfunction

   function automatic logic [8:0] random_dim;
      case ($urandom_range(5))
         0: return 9'd4;
         1: return 9'd256;
         2: return 9'($urandom);                    // out of range gets limited
         default: return 9'($urandom_range(4, 40));
      endcase
   endfunction

   // runs register phases of about 180 transactions until total have been sent
   task automatic test_random_phases(input int total);
      int phase, phase_end;
      phase = 0;
      while (items_sent < total) begin
         configure(2'($urandom_range(3)), 2'($urandom_range(3)), random_dim(),
                   random_dim(), random_scale(), random_scale(), 24'($urandom),
                   1'($urandom_range(1)));
         idle_on = (phase != 2);                    // one phase at full rate
         phase_end = items_sent + 180;
         while (items_sent < phase_end && items_sent < total) begin
            if ($urandom_range(99) < 25)
               load_texel($urandom_range(0, 255), $urandom_range(0, 255), $urandom);
            else
               sample_at(random_coord(), random_coord());
         end
         phase++;
      end
      idle_on = 1'b1;
   endtask

   // ---------------------------------------------------------------- checking
   always @(posedge clock) begin
      rsp_tready <= idle_on ? ($urandom_range(99) >= 16) : 1'b1;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_samples.size() == 0) begin
            $error("unexpected result transaction");
            failed = 1'b1;
         end else begin
            rsp_type exp_r;
            exp_r = pending_samples.pop_front();
            if (rsp_tdata[7:0] !== exp_r.red) begin
               $error("red expected %0h actual %0h", exp_r.red, rsp_tdata[7:0]);
               failed = 1'b1;
            end
            if (rsp_tdata[15:8] !== exp_r.green) begin
               $error("green expected %0h actual %0h", exp_r.green, rsp_tdata[15:8]);
               failed = 1'b1;
            end
            if (rsp_tdata[23:16] !== exp_r.blue) begin
               $error("blue expected %0h actual %0h", exp_r.blue, rsp_tdata[23:16]);
               failed = 1'b1;
            end
            if (rsp_tdata[31:24] !== exp_r.alpha_out) begin
               $error("alpha_out expected %0h actual %0h", exp_r.alpha_out,
                      rsp_tdata[31:24]);
               failed = 1'b1;
            end
            if (rsp_tdata[32] !== exp_r.opaque) begin
               $error("opaque expected %0b actual %0b", exp_r.opaque, rsp_tdata[32]);
               failed = 1'b1;
            end
            if (rsp_tuser !== exp_r.outside) begin
               $error("outside expected %0b actual %0b", exp_r.outside, rsp_tuser);
               failed = 1'b1;
            end
         end
      end
   end

   // watchdog
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT_CYCLES) begin
         $display("status: fail");
         $finish;
      end
   end

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      test_random_phases(1550);
      drain();
      if (failed || pending_samples.size() != 0) begin
         $display("status: fail");
      end else begin
         $display("status: pass");
      end
      $finish;
   end

endmodule
